// ===== hdl/eer_pkg.sv =====
// Shared types, constants and fixed-point helpers for the elastic element residual block.
// Used by eer_front, eer_queue, eer_back and the top level; depends on nothing else.
package eer_pkg;

	localparam int MAX_NODES = 20;
	localparam int MAX_POINTS = 16;
	localparam int FRAC_BITS = 16;

	localparam int NCW = $clog2(MAX_NODES + 1);
	localparam int NAW = $clog2(MAX_NODES);
	localparam int PCW = $clog2(MAX_POINTS + 1);
	localparam int PAW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int SG_DEPTH = MAX_POINTS * MAX_NODES;
	localparam int SG_AW = $clog2(SG_DEPTH);
	localparam int QDEPTH = 2;
	localparam int QAW = $clog2(QDEPTH);

	localparam logic [2:0] CFG_L2M = 3'd0;
	localparam logic [2:0] CFG_LAMBDA = 3'd1;
	localparam logic [2:0] CFG_SHEAR = 3'd2;
	localparam logic [2:0] CFG_NODES = 3'd3;
	localparam logic [2:0] CFG_POINTS = 3'd4;

	localparam logic [4:0] JAC_DET_ROW = 5'd3;

	typedef enum logic [1:0] {
		ACT_SG = 2'd0,
		ACT_WT = 2'd1,
		ACT_JAC = 2'd2,
		ACT_NODE = 2'd3
	} act_t;

	typedef struct packed {
		act_t action;
		logic [3:0] pt;
		logic [4:0] nd;
		logic [31:0] addr;
		logic signed [31:0] vx;
		logic signed [31:0] vy;
		logic signed [31:0] vz;
		logic signed [31:0] fx;
		logic signed [31:0] fy;
		logic signed [31:0] fz;
		logic fin;
	} item_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
		logic signed [31:0] r;
		if (x > 64'sh0000_0000_7FFF_FFFF) r = 32'sh7FFF_FFFF;
		else if (x < -64'sh0000_0000_8000_0000) r = 32'sh8000_0000;
		else r = x[31:0];
		return r;
	endfunction

	function automatic logic signed [47:0] sat48(input logic signed [63:0] x);
		logic signed [47:0] r;
		if (x > 64'sh0000_7FFF_FFFF_FFFF) r = 48'sh7FFF_FFFF_FFFF;
		else if (x < -64'sh0000_8000_0000_0000) r = 48'sh8000_0000_0000;
		else r = x[47:0];
		return r;
	endfunction

	function automatic logic signed [31:0] lane(input logic [95:0] v, input logic [1:0] n);
		logic signed [31:0] r;
		case (n)
			2'd0: r = v[31:0];
			2'd1: r = v[63:32];
			default: r = v[95:64];
		endcase
		return r;
	endfunction

	function automatic logic [NCW-1:0] clamp_nodes(input logic [4:0] v);
		logic [NCW-1:0] r;
		if (v == 5'd0) r = NCW'(1);
		else if (int'(v) > MAX_NODES) r = NCW'(MAX_NODES);
		else r = NCW'(v);
		return r;
	endfunction

	function automatic logic [PCW-1:0] clamp_points(input logic [4:0] v);
		logic [PCW-1:0] r;
		if (v == 5'd0) r = PCW'(1);
		else if (int'(v) > MAX_POINTS) r = PCW'(MAX_POINTS);
		else r = PCW'(v);
		return r;
	endfunction

endpackage

// ===== hdl/eer_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
// Stand-alone; used for the five RAM stores of the back end.
module eer_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input logic clk,
	input logic we,
	input logic [AW-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [AW-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== hdl/eer_front.sv =====
// Front end: accepts input items, drops out-of-range loads and nodes, and marks the
// node that completes an element. Uses eer_pkg; feeds eer_queue.
module eer_front (
	input logic in_valid,
	output logic in_stall,
	input logic [1:0] action,
	input logic [3:0] point_index,
	input logic [4:0] node_index,
	input logic [31:0] node_address,
	input logic signed [31:0] val_x,
	input logic signed [31:0] val_y,
	input logic signed [31:0] val_z,
	input logic signed [31:0] force_in_x,
	input logic signed [31:0] force_in_y,
	input logic signed [31:0] force_in_z,
	input logic [eer_pkg::NCW-1:0] nn,
	input logic q_full,
	output logic push,
	output eer_pkg::item_t item
);

	logic keep;
	eer_pkg::act_t act;

	assign act = eer_pkg::act_t'(action);

	always_comb begin
		case (act)
			eer_pkg::ACT_SG: keep = (int'(point_index) < eer_pkg::MAX_POINTS) &&
				(int'(node_index) < eer_pkg::MAX_NODES);
			eer_pkg::ACT_WT: keep = int'(point_index) < eer_pkg::MAX_POINTS;
			eer_pkg::ACT_JAC: keep = node_index <= eer_pkg::JAC_DET_ROW;
			eer_pkg::ACT_NODE: keep = int'(node_index) < int'(nn);
			default: keep = 1'b0;
		endcase
	end

	always_comb begin
		item.action = act;
		item.pt = point_index;
		item.nd = node_index;
		item.addr = node_address;
		item.vx = val_x;
		item.vy = val_y;
		item.vz = val_z;
		item.fx = force_in_x;
		item.fy = force_in_y;
		item.fz = force_in_z;
		// The node with the highest index closes the element and starts the computation.
		item.fin = (act == eer_pkg::ACT_NODE) && (int'(node_index) == int'(nn) - 1);
	end

	assign in_stall = q_full;
	assign push = in_valid && !q_full && keep;

endmodule

// ===== hdl/eer_queue.sv =====
// Short item queue between the front end and the back end.
// Uses eer_pkg for the item type and depth.
module eer_queue (
	input logic clk,
	input logic arst_n,
	input logic push,
	input eer_pkg::item_t wdata,
	output logic full,
	input logic pop,
	output logic q_valid,
	output eer_pkg::item_t head
);

	eer_pkg::item_t mem_q [eer_pkg::QDEPTH];
	logic [eer_pkg::QAW-1:0] wr_ptr_q;
	logic [eer_pkg::QAW-1:0] rd_ptr_q;
	logic [eer_pkg::QAW:0] count_q;

	assign full = int'(count_q) == eer_pkg::QDEPTH;
	assign q_valid = count_q != '0;
	assign head = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

// ===== hdl/eer_back.sv =====
// Back end: stores loads and nodes, runs the element computation on one shared
// multiplier, and returns one force item per node. Uses eer_pkg and eer_ram.
module eer_back (
	input logic clk,
	input logic arst_n,
	input logic [eer_pkg::NCW-1:0] nn,
	input logic [eer_pkg::PCW-1:0] np,
	input logic signed [31:0] l2m,
	input logic signed [31:0] lam,
	input logic signed [31:0] mu,
	input logic q_valid,
	input eer_pkg::item_t q_item,
	output logic pop,
	output logic out_valid,
	input logic out_stall,
	output logic [31:0] out_address,
	output logic [4:0] out_node,
	output logic signed [31:0] force_x,
	output logic signed [31:0] force_y,
	output logic signed [31:0] force_z,
	output logic last
);

	typedef enum logic [12:0] {
		S_IDLE = 13'b0000000000001,
		S_GG_RD = 13'b0000000000010,
		S_GG_MAC = 13'b0000000000100,
		S_GG_WR = 13'b0000000001000,
		S_ST_RD = 13'b0000000010000,
		S_ST_MAC = 13'b0000000100000,
		S_SS_OP = 13'b0000001000000,
		S_FC_RD = 13'b0000010000000,
		S_FC_MAC = 13'b0000100000000,
		S_FC_WR = 13'b0001000000000,
		S_OUT_RD = 13'b0010000000000,
		S_OUT_LD = 13'b0100000000000,
		S_OUT_HOLD = 13'b1000000000000
	} state_t;

	// Steps of the stress calculation at one integration point.
	typedef enum logic [4:0] {
		SS_WDET, SS_N0A, SS_N0B, SS_N0C, SS_N0S, SS_N1A, SS_N1B, SS_N1C, SS_N1S,
		SS_N2A, SS_N2B, SS_N2C, SS_N2S, SS_S01, SS_S01S, SS_S12, SS_S12S, SS_S02, SS_S02S
	} ss_step_t;

	state_t state_q;
	ss_step_t sc_q;
	logic ph_q;
	logic [eer_pkg::PCW-1:0] p_q;
	logic [eer_pkg::NCW-1:0] i_q;
	logic [1:0] j_q;
	logic [1:0] k_q;
	logic signed [63:0] prod_q;
	logic signed [63:0] acc_q;
	logic signed [31:0] row_q [3];
	logic signed [47:0] strain_q [9];
	logic signed [31:0] jac_q [10];
	logic signed [31:0] wgt_q [eer_pkg::MAX_POINTS];
	logic signed [31:0] wdet_q;
	logic signed [31:0] t_q;
	logic signed [31:0] sigd_q [3];
	logic signed [31:0] sig01_q;
	logic signed [31:0] sig12_q;
	logic signed [31:0] sig02_q;
	logic out_valid_q;
	logic [31:0] out_address_q;
	logic [4:0] out_node_q;
	logic signed [31:0] fx_q;
	logic signed [31:0] fy_q;
	logic signed [31:0] fz_q;
	logic last_q;

	logic [95:0] sg_rd;
	logic [95:0] gg_rd;
	logic [95:0] dp_rd;
	logic [95:0] fo_rd;
	logic [31:0] ad_rd;
	logic sg_we;
	logic node_we;
	logic gg_we;
	logic fo_we;
	logic [eer_pkg::SG_AW-1:0] sg_waddr;
	logic [eer_pkg::SG_AW-1:0] sg_raddr;
	logic [eer_pkg::NAW-1:0] nd_addr;
	logic [eer_pkg::NAW-1:0] i_addr;
	logic [95:0] row_w;
	logic [95:0] fo_wdata;

	logic signed [31:0] mul_a;
	logic signed [31:0] mul_b;
	logic signed [63:0] qv;
	logic signed [63:0] nacc;
	logic signed [31:0] e_w [9];
	logic signed [31:0] sig_w;
	logic [3:0] jk_idx;
	logic i_last;
	logic p_last;

	assign qv = prod_q >>> eer_pkg::FRAC_BITS;
	assign jk_idx = 4'(3 * int'(j_q) + int'(k_q));
	assign i_last = eer_pkg::NCW'(i_q + 1'b1) == nn;
	assign p_last = eer_pkg::PCW'(p_q + 1'b1) == np;
	assign row_w = {row_q[2], row_q[1], row_q[0]};

	always_comb begin
		for (int n = 0; n < 9; n++) begin
			e_w[n] = eer_pkg::sat32(64'(strain_q[n]));
		end
	end

	// Stress tensor entry for row j, column k; the shear entries are symmetric.
	always_comb begin
		case ({j_q, k_q})
			4'b0000: sig_w = sigd_q[0];
			4'b0101: sig_w = sigd_q[1];
			4'b1010: sig_w = sigd_q[2];
			4'b0001, 4'b0100: sig_w = sig01_q;
			4'b0110, 4'b1001: sig_w = sig12_q;
			default: sig_w = sig02_q;
		endcase
	end

	// Store ports
	assign pop = (state_q == S_IDLE) && q_valid;
	assign sg_we = pop && (q_item.action == eer_pkg::ACT_SG);
	assign node_we = pop && (q_item.action == eer_pkg::ACT_NODE);
	assign gg_we = state_q == S_GG_WR;
	assign fo_we = node_we || (state_q == S_FC_WR);
	assign fo_wdata = node_we ? {q_item.fz, q_item.fy, q_item.fx} : row_w;
	assign sg_waddr = eer_pkg::SG_AW'(int'(q_item.pt) * eer_pkg::MAX_NODES + int'(q_item.nd));
	assign sg_raddr = eer_pkg::SG_AW'(int'(p_q) * eer_pkg::MAX_NODES + int'(i_q));
	assign nd_addr = eer_pkg::NAW'(q_item.nd);
	assign i_addr = i_q[eer_pkg::NAW-1:0];

	eer_ram #(.WIDTH(96), .DEPTH(eer_pkg::SG_DEPTH)) u_sg_ram (
		.clk(clk), .we(sg_we), .waddr(sg_waddr), .wdata({q_item.vz, q_item.vy, q_item.vx}),
		.raddr(sg_raddr), .rdata(sg_rd)
	);

	eer_ram #(.WIDTH(96), .DEPTH(eer_pkg::MAX_NODES)) u_dp_ram (
		.clk(clk), .we(node_we), .waddr(nd_addr), .wdata({q_item.vz, q_item.vy, q_item.vx}),
		.raddr(i_addr), .rdata(dp_rd)
	);

	eer_ram #(.WIDTH(96), .DEPTH(eer_pkg::MAX_NODES)) u_fo_ram (
		.clk(clk), .we(fo_we), .waddr(node_we ? nd_addr : i_addr), .wdata(fo_wdata),
		.raddr(i_addr), .rdata(fo_rd)
	);

	eer_ram #(.WIDTH(32), .DEPTH(eer_pkg::MAX_NODES)) u_ad_ram (
		.clk(clk), .we(node_we), .waddr(nd_addr), .wdata(q_item.addr),
		.raddr(i_addr), .rdata(ad_rd)
	);

	eer_ram #(.WIDTH(96), .DEPTH(eer_pkg::MAX_NODES)) u_gg_ram (
		.clk(clk), .we(gg_we), .waddr(i_addr), .wdata(row_w),
		.raddr(i_addr), .rdata(gg_rd)
	);

	// Multiplier operand selection
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_GG_MAC: begin
				mul_a = eer_pkg::lane(sg_rd, j_q);
				mul_b = jac_q[jk_idx];
			end
			S_ST_MAC: begin
				mul_a = eer_pkg::lane(gg_rd, k_q);
				mul_b = eer_pkg::lane(dp_rd, j_q);
			end
			S_FC_MAC: begin
				mul_a = eer_pkg::lane(gg_rd, j_q);
				mul_b = sig_w;
			end
			S_SS_OP: begin
				case (sc_q)
					SS_WDET: begin
						mul_a = jac_q[9];
						mul_b = wgt_q[eer_pkg::PAW'(p_q)];
					end
					SS_N0A: begin mul_a = l2m; mul_b = e_w[0]; end
					SS_N0B: begin mul_a = lam; mul_b = e_w[4]; end
					SS_N0C: begin mul_a = lam; mul_b = e_w[8]; end
					SS_N1A: begin mul_a = lam; mul_b = e_w[0]; end
					SS_N1B: begin mul_a = l2m; mul_b = e_w[4]; end
					SS_N1C: begin mul_a = lam; mul_b = e_w[8]; end
					SS_N2A: begin mul_a = lam; mul_b = e_w[0]; end
					SS_N2B: begin mul_a = lam; mul_b = e_w[4]; end
					SS_N2C: begin mul_a = l2m; mul_b = e_w[8]; end
					SS_S01: begin
						mul_a = eer_pkg::sat32(64'(e_w[1]) + 64'(e_w[3]));
						mul_b = mu;
					end
					SS_S12: begin
						mul_a = eer_pkg::sat32(64'(e_w[5]) + 64'(e_w[7]));
						mul_b = mu;
					end
					SS_S02: begin
						mul_a = eer_pkg::sat32(64'(e_w[2]) + 64'(e_w[6]));
						mul_b = mu;
					end
					default: begin
						mul_a = t_q;
						mul_b = wdet_q;
					end
				endcase
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Running sum of the dot product; the force sum starts from the stored force.
	always_comb begin
		if (j_q != 2'd0) nacc = acc_q + qv;
		else if (state_q == S_FC_MAC) nacc = 64'(eer_pkg::lane(fo_rd, k_q)) + qv;
		else nacc = qv;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			sc_q <= SS_WDET;
			ph_q <= 1'b0;
			p_q <= '0;
			i_q <= '0;
			j_q <= '0;
			k_q <= '0;
			out_valid_q <= 1'b0;
			for (int n = 0; n < 9; n++) begin
				strain_q[n] <= '0;
			end
		end else begin
			case (state_q)
				S_IDLE: begin
					if (q_valid && q_item.fin) begin
						p_q <= '0;
						i_q <= '0;
						state_q <= S_GG_RD;
					end
				end
				S_GG_RD: state_q <= S_GG_MAC;
				S_GG_MAC: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						if (j_q == 2'd2) begin
							j_q <= '0;
							if (k_q == 2'd2) begin
								k_q <= '0;
								state_q <= S_GG_WR;
							end else begin
								k_q <= k_q + 1'b1;
							end
						end else begin
							j_q <= j_q + 1'b1;
						end
					end
				end
				S_GG_WR: begin
					if (i_last) begin
						i_q <= '0;
						for (int n = 0; n < 9; n++) begin
							strain_q[n] <= '0;
						end
						state_q <= S_ST_RD;
					end else begin
						i_q <= i_q + 1'b1;
						state_q <= S_GG_RD;
					end
				end
				S_ST_RD: state_q <= S_ST_MAC;
				S_ST_MAC: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						strain_q[jk_idx] <= eer_pkg::sat48(64'(strain_q[jk_idx]) + qv);
						if (k_q == 2'd2) begin
							k_q <= '0;
							if (j_q == 2'd2) begin
								j_q <= '0;
								if (i_last) begin
									i_q <= '0;
									sc_q <= SS_WDET;
									state_q <= S_SS_OP;
								end else begin
									i_q <= i_q + 1'b1;
									state_q <= S_ST_RD;
								end
							end else begin
								j_q <= j_q + 1'b1;
							end
						end else begin
							k_q <= k_q + 1'b1;
						end
					end
				end
				S_SS_OP: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						if (sc_q == SS_S02S) begin
							state_q <= S_FC_RD;
						end else begin
							sc_q <= ss_step_t'(sc_q + 1'b1);
						end
					end
				end
				S_FC_RD: state_q <= S_FC_MAC;
				S_FC_MAC: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						if (j_q == 2'd2) begin
							j_q <= '0;
							if (k_q == 2'd2) begin
								k_q <= '0;
								state_q <= S_FC_WR;
							end else begin
								k_q <= k_q + 1'b1;
							end
						end else begin
							j_q <= j_q + 1'b1;
						end
					end
				end
				S_FC_WR: begin
					if (i_last) begin
						i_q <= '0;
						if (p_last) begin
							state_q <= S_OUT_RD;
						end else begin
							p_q <= p_q + 1'b1;
							state_q <= S_GG_RD;
						end
					end else begin
						i_q <= i_q + 1'b1;
						state_q <= S_FC_RD;
					end
				end
				S_OUT_RD: state_q <= S_OUT_LD;
				S_OUT_LD: begin
					out_valid_q <= 1'b1;
					state_q <= S_OUT_HOLD;
				end
				S_OUT_HOLD: begin
					if (!out_stall) begin
						out_valid_q <= 1'b0;
						if (i_last) begin
							i_q <= '0;
							state_q <= S_IDLE;
						end else begin
							i_q <= i_q + 1'b1;
							state_q <= S_OUT_RD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers without reset
	always_ff @(posedge clk) begin
		if (!ph_q) begin
			prod_q <= mul_a * mul_b;
		end
		if (pop) begin
			case (q_item.action)
				eer_pkg::ACT_WT: wgt_q[eer_pkg::PAW'(q_item.pt)] <= q_item.vx;
				eer_pkg::ACT_JAC: begin
					case (q_item.nd)
						5'd0: begin
							jac_q[0] <= q_item.vx; jac_q[1] <= q_item.vy; jac_q[2] <= q_item.vz;
						end
						5'd1: begin
							jac_q[3] <= q_item.vx; jac_q[4] <= q_item.vy; jac_q[5] <= q_item.vz;
						end
						5'd2: begin
							jac_q[6] <= q_item.vx; jac_q[7] <= q_item.vy; jac_q[8] <= q_item.vz;
						end
						default: jac_q[9] <= q_item.vx;
					endcase
				end
				default: ;
			endcase
		end
		if (ph_q && (state_q == S_GG_MAC || state_q == S_FC_MAC)) begin
			acc_q <= nacc;
			if (j_q == 2'd2) begin
				row_q[k_q] <= eer_pkg::sat32(nacc);
			end
		end
		if (ph_q && state_q == S_SS_OP) begin
			case (sc_q)
				SS_WDET: wdet_q <= eer_pkg::sat32(qv);
				SS_N0A, SS_N1A, SS_N2A: acc_q <= qv;
				SS_N0B, SS_N1B, SS_N2B: acc_q <= acc_q + qv;
				SS_N0C, SS_N1C, SS_N2C: t_q <= eer_pkg::sat32(acc_q + qv);
				SS_S01, SS_S12, SS_S02: t_q <= eer_pkg::sat32(qv);
				SS_N0S: sigd_q[0] <= eer_pkg::sat32(qv);
				SS_N1S: sigd_q[1] <= eer_pkg::sat32(qv);
				SS_N2S: sigd_q[2] <= eer_pkg::sat32(qv);
				SS_S01S: sig01_q <= eer_pkg::sat32(qv);
				SS_S12S: sig12_q <= eer_pkg::sat32(qv);
				default: sig02_q <= eer_pkg::sat32(qv);
			endcase
		end
		if (state_q == S_OUT_LD) begin
			out_address_q <= ad_rd;
			out_node_q <= 5'(i_q);
			fx_q <= eer_pkg::lane(fo_rd, 2'd0);
			fy_q <= eer_pkg::lane(fo_rd, 2'd1);
			fz_q <= eer_pkg::lane(fo_rd, 2'd2);
			last_q <= i_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_address = out_address_q;
	assign out_node = out_node_q;
	assign force_x = fx_q;
	assign force_y = fy_q;
	assign force_z = fz_q;
	assign last = last_q;

	a_out_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (i_q < nn))
		else $error("result item for a node beyond the element");

	a_pop_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (state_q == S_IDLE))
		else $error("queue popped while computing");

	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT_HOLD && out_stall) |=> (state_q == S_OUT_HOLD && out_valid_q))
		else $error("stalled result item dropped");

	a_point_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_GG_MAC || state_q == S_FC_MAC) |-> (p_q < np))
		else $error("integration point counter overran");

endmodule

// ===== hdl/elastic_element_residual.sv =====
// Top level of the elastic element residual block: configuration registers, front end,
// item queue and back end. Uses eer_pkg, eer_front, eer_queue and eer_back.

// Load items (shape gradients, weights, Jacobian rows) and nodes other than the last are stored
// as taken; a two-entry queue lets the front keep accepting until it is full. The last node of
// an element starts the computation on one shared 32x32 multiplier: for each integration point,
// gradient and strain passes over the nodes, the stress, then a force pass; after the last point,
// one result per node. No item is taken from the queue until the last result of the element has
// left. Configuration must be written only while the block idles; the block does not enforce it.
module elastic_element_residual (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [2:0] cfg_index,
	input logic [31:0] cfg_data,
	input logic in_valid,
	output logic in_stall,
	input logic [1:0] action,
	input logic [3:0] point_index,
	input logic [4:0] node_index,
	input logic [31:0] node_address,
	input logic signed [31:0] val_x,
	input logic signed [31:0] val_y,
	input logic signed [31:0] val_z,
	input logic signed [31:0] force_in_x,
	input logic signed [31:0] force_in_y,
	input logic signed [31:0] force_in_z,
	output logic out_valid,
	input logic out_stall,
	output logic [31:0] out_address,
	output logic [4:0] out_node,
	output logic signed [31:0] force_x,
	output logic signed [31:0] force_y,
	output logic signed [31:0] force_z,
	output logic last
);

	logic signed [31:0] l2m_q;
	logic signed [31:0] lam_q;
	logic signed [31:0] mu_q;
	logic [4:0] nodes_q;
	logic [4:0] points_q;
	logic [eer_pkg::NCW-1:0] nn;
	logic [eer_pkg::PCW-1:0] np;
	logic push;
	logic q_full;
	logic q_valid;
	logic pop;
	eer_pkg::item_t front_item;
	eer_pkg::item_t head_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			l2m_q <= '0;
			lam_q <= '0;
			mu_q <= '0;
			nodes_q <= 5'd4;
			points_q <= 5'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				eer_pkg::CFG_L2M: l2m_q <= cfg_data;
				eer_pkg::CFG_LAMBDA: lam_q <= cfg_data;
				eer_pkg::CFG_SHEAR: mu_q <= cfg_data;
				eer_pkg::CFG_NODES: nodes_q <= cfg_data[4:0];
				eer_pkg::CFG_POINTS: points_q <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	assign nn = eer_pkg::clamp_nodes(nodes_q);
	assign np = eer_pkg::clamp_points(points_q);

	eer_front u_front (
		.in_valid(in_valid), .in_stall(in_stall), .action(action),
		.point_index(point_index), .node_index(node_index), .node_address(node_address),
		.val_x(val_x), .val_y(val_y), .val_z(val_z),
		.force_in_x(force_in_x), .force_in_y(force_in_y), .force_in_z(force_in_z),
		.nn(nn), .q_full(q_full), .push(push), .item(front_item)
	);

	eer_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .wdata(front_item), .full(q_full),
		.pop(pop), .q_valid(q_valid), .head(head_item)
	);

	eer_back u_back (
		.clk(clk), .arst_n(arst_n), .nn(nn), .np(np), .l2m(l2m_q), .lam(lam_q), .mu(mu_q),
		.q_valid(q_valid), .q_item(head_item), .pop(pop),
		.out_valid(out_valid), .out_stall(out_stall), .out_address(out_address),
		.out_node(out_node), .force_x(force_x), .force_y(force_y), .force_z(force_z),
		.last(last)
	);

endmodule

// ===== tb/elastic_element_residual_tb.sv =====
// Self-checking testbench for elastic_element_residual: a directed table, then random elements.
// Holds its own predictor of the element residual kernel; depends on eer_pkg and the RTL.
`timescale 1ns / 1ps

module elastic_element_residual_tb;

	typedef struct {
		eer_pkg::act_t act;
		logic [3:0] pt;
		logic [4:0] nd;
		logic [31:0] addr;
		logic signed [31:0] vx, vy, vz, fx, fy, fz;
		bit typed;
	} stim_t;

	typedef struct {
		logic [31:0] addr;
		logic [4:0] node;
		logic signed [31:0] fx, fy, fz;
		logic lst;
	} force_result_t;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we;
	logic [2:0] cfg_index;
	logic [31:0] cfg_data;
	logic in_valid, in_stall;
	logic [1:0] action;
	logic [3:0] point_index;
	logic [4:0] node_index;
	logic [31:0] node_address;
	logic signed [31:0] val_x, val_y, val_z, force_in_x, force_in_y, force_in_z;
	logic out_valid, out_stall;
	logic [31:0] out_address;
	logic [4:0] out_node;
	logic signed [31:0] force_x, force_y, force_z;
	logic last;

	elastic_element_residual dut (.*);

	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	// Predictor state.
	logic signed [31:0] grad_ref [eer_pkg::MAX_POINTS][eer_pkg::MAX_NODES][3];
	logic signed [31:0] weight_ref [eer_pkg::MAX_POINTS];
	logic signed [31:0] jac_ref [10];
	logic signed [31:0] disp_ref [eer_pkg::MAX_NODES][3];
	logic signed [31:0] frc_ref [eer_pkg::MAX_NODES][3];
	logic [31:0] addr_ref [eer_pkg::MAX_NODES];
	logic signed [31:0] coef_l2m, coef_lam, coef_mu;
	logic [4:0] nodes_reg, points_reg;

	logic signed [31:0] typed_force [eer_pkg::MAX_NODES][3];
	logic [31:0] typed_addr [eer_pkg::MAX_NODES];

	force_result_t expected_forces[$];
	int errors = 0;
	int burst_left = 0;

	function automatic logic signed [31:0] clip32(input longint x);
		if (x > 64'sd2147483647) return 32'sh7FFF_FFFF;
		if (x < -64'sd2147483648) return 32'sh8000_0000;
		return 32'(x);
	endfunction

	function automatic longint clip48(input longint x);
		if (x > 64'sh7FFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF;
		if (x < -64'sh8000_0000_0000) return -64'sh8000_0000_0000;
		return x;
	endfunction

	// Exact product, then an arithmetic shift, which rounds toward minus infinity.
	function automatic longint fxmul(input logic signed [31:0] a, input logic signed [31:0] b);
		longint prod;
		prod = longint'(a) * longint'(b);
		return prod >>> eer_pkg::FRAC_BITS;
	endfunction

	function automatic int node_count();
		if (nodes_reg == 0) return 1;
		if (nodes_reg > eer_pkg::MAX_NODES) return eer_pkg::MAX_NODES;
		return int'(nodes_reg);
	endfunction

	function automatic int point_total();
		if (points_reg == 0) return 1;
		if (points_reg > eer_pkg::MAX_POINTS) return eer_pkg::MAX_POINTS;
		return int'(points_reg);
	endfunction

	function automatic void solve_element(input int nn, input int np);
		logic signed [31:0] gg [eer_pkg::MAX_NODES][3];
		logic signed [31:0] e [9];
		logic signed [31:0] sig [9];
		logic signed [31:0] t, wdet;
		longint strain [9];
		longint acc;
		int sp [3][2];
		sp = '{'{1, 3}, '{5, 7}, '{2, 6}};
		for (int p = 0; p < np; p++) begin
			for (int i = 0; i < nn; i++)
				for (int k = 0; k < 3; k++) begin
					acc = 0;
					for (int j = 0; j < 3; j++)
						acc += fxmul(grad_ref[p][i][j], jac_ref[3*j+k]);
					gg[i][k] = clip32(acc);
				end
			for (int q = 0; q < 9; q++)
				strain[q] = 0;
			for (int i = 0; i < nn; i++)
				for (int j = 0; j < 3; j++)
					for (int k = 0; k < 3; k++)
						strain[3*j+k] = clip48(strain[3*j+k] + fxmul(gg[i][k], disp_ref[i][j]));
			for (int q = 0; q < 9; q++)
				e[q] = clip32(strain[q]);
			wdet = clip32(fxmul(jac_ref[9], weight_ref[p]));
			for (int i = 0; i < 3; i++) begin
				acc = 0;
				for (int j = 0; j < 3; j++)
					acc += fxmul(i == j ? coef_l2m : coef_lam, e[4*j]);
				t = clip32(acc);
				sig[4*i] = clip32(fxmul(t, wdet));
			end
			for (int s = 0; s < 3; s++) begin
				t = clip32(fxmul(clip32(longint'(e[sp[s][0]]) + longint'(e[sp[s][1]])), coef_mu));
				sig[sp[s][0]] = clip32(fxmul(t, wdet));
				sig[sp[s][1]] = sig[sp[s][0]];
			end
			for (int i = 0; i < nn; i++)
				for (int k = 0; k < 3; k++) begin
					acc = longint'(frc_ref[i][k]);
					for (int j = 0; j < 3; j++)
						acc += fxmul(gg[i][j], sig[3*j+k]);
					frc_ref[i][k] = clip32(acc);
				end
		end
	endfunction

	// Updates the predictor with one accepted item and queues the node forces it releases.
	function automatic void predict_item(input stim_t s);
		int nn;
		force_result_t r;
		nn = node_count();
		case (s.act)
			eer_pkg::ACT_SG: begin
				if (s.nd < eer_pkg::MAX_NODES) begin
					grad_ref[s.pt][s.nd][0] = s.vx;
					grad_ref[s.pt][s.nd][1] = s.vy;
					grad_ref[s.pt][s.nd][2] = s.vz;
				end
			end
			eer_pkg::ACT_WT: weight_ref[s.pt] = s.vx;
			eer_pkg::ACT_JAC: begin
				if (s.nd < eer_pkg::JAC_DET_ROW) begin
					jac_ref[3*s.nd] = s.vx;
					jac_ref[3*s.nd+1] = s.vy;
					jac_ref[3*s.nd+2] = s.vz;
				end else if (s.nd == eer_pkg::JAC_DET_ROW) begin
					jac_ref[9] = s.vx;
				end
			end
			default: begin
				if (s.nd < nn) begin
					addr_ref[s.nd] = s.addr;
					disp_ref[s.nd] = '{s.vx, s.vy, s.vz};
					frc_ref[s.nd] = '{s.fx, s.fy, s.fz};
					if (s.nd == nn - 1) begin
						solve_element(nn, point_total());
						for (int i = 0; i < nn; i++) begin
							r.node = 5'(i);
							r.lst = (i == nn - 1);
							if (s.typed) begin
								r.addr = typed_addr[i];
								r.fx = typed_force[i][0];
								r.fy = typed_force[i][1];
								r.fz = typed_force[i][2];
							end else begin
								r.addr = addr_ref[i];
								r.fx = frc_ref[i][0];
								r.fy = frc_ref[i][1];
								r.fz = frc_ref[i][2];
							end
							expected_forces.push_back(r);
						end
					end
				end
			end
		endcase
	endfunction

	function automatic logic signed [31:0] rand_word();
		logic signed [31:0] corner [5];
		corner = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF, 32'h0001_0000};
		case ($urandom_range(0, 9))
			0: return $urandom;
			1: return corner[$urandom_range(0, 4)];
			default: return 32'($urandom_range(0, 262143)) - 32'd131072;
		endcase
	endfunction

	// Sender: bursts of random length separated by random gaps, sometimes none.
	task automatic send(input stim_t s);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		in_valid <= 1'b1;
		action <= s.act;
		point_index <= s.pt;
		node_index <= s.nd;
		node_address <= s.addr;
		val_x <= s.vx;
		val_y <= s.vy;
		val_z <= s.vz;
		force_in_x <= s.fx;
		force_in_y <= s.fy;
		force_in_z <= s.fz;
		do @(posedge clk); while (in_stall);
		predict_item(s);
		burst_left--;
	endtask

	function automatic stim_t make_item(input eer_pkg::act_t a, input int pt, input int nd);
		stim_t s;
		s.act = a;
		s.pt = 4'(pt);
		s.nd = 5'(nd);
		s.addr = $urandom;
		s.vx = rand_word();
		s.vy = rand_word();
		s.vz = rand_word();
		s.fx = rand_word();
		s.fy = rand_word();
		s.fz = rand_word();
		s.typed = 0;
		return s;
	endfunction

	// Waits until every node force is out and queued loads have drained, then writes registers.
	task automatic configure(input logic [31:0] l2m, input logic [31:0] lam,
			input logic [31:0] mu, input logic [31:0] nodes, input logic [31:0] points);
		logic [31:0] vals [5];
		logic [2:0] idx [5];
		vals = '{l2m, lam, mu, nodes, points};
		idx = '{eer_pkg::CFG_L2M, eer_pkg::CFG_LAMBDA, eer_pkg::CFG_SHEAR,
			eer_pkg::CFG_NODES, eer_pkg::CFG_POINTS};
		in_valid <= 1'b0;
		while (expected_forces.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
		for (int i = 0; i < 5; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= vals[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		coef_l2m = l2m;
		coef_lam = lam;
		coef_mu = mu;
		nodes_reg = nodes[4:0];
		points_reg = points[4:0];
		burst_left = 0;
	endtask

	task automatic run_phase(input logic [31:0] l2m, input logic [31:0] lam,
			input logic [31:0] mu, input logic [31:0] nodes, input logic [31:0] points,
			input int budget);
		int nn, np, sent;
		stim_t s;
		configure(l2m, lam, mu, nodes, points);
		nn = node_count();
		np = point_total();
		// Fill every table entry that an element of this size reads.
		for (int p = 0; p < np; p++) begin
			send(make_item(eer_pkg::ACT_WT, p, $urandom_range(0, 31)));
			for (int n = 0; n < nn; n++)
				send(make_item(eer_pkg::ACT_SG, p, n));
		end
		for (int r = 0; r < 4; r++)
			send(make_item(eer_pkg::ACT_JAC, $urandom_range(0, 15), r));
		for (int n = 0; n < nn; n++)
			send(make_item(eer_pkg::ACT_NODE, $urandom_range(0, 15), n));
		sent = 0;
		while (sent < budget) begin
			if ($urandom_range(0, 3) != 0) begin
				if ($urandom_range(0, 1) == 0)
					for (int r = 0; r < 4; r++) begin
						send(make_item(eer_pkg::ACT_JAC, $urandom_range(0, 15), r));
						sent++;
					end
				// Some nodes are left out; they keep their stored values.
				for (int n = 0; n < nn; n++)
					if (n == nn - 1 || $urandom_range(0, 7) != 0) begin
						send(make_item(eer_pkg::ACT_NODE, $urandom_range(0, 15), n));
						sent++;
					end
			end else begin
				s = make_item(eer_pkg::act_t'($urandom_range(0, 3)), $urandom_range(0, 15),
					$urandom_range(0, 31));
				send(s);
				if (!((s.act == eer_pkg::ACT_SG && s.nd >= eer_pkg::MAX_NODES) ||
						(s.act == eer_pkg::ACT_JAC && s.nd > eer_pkg::JAC_DET_ROW) ||
						(s.act == eer_pkg::ACT_NODE && s.nd >= nn)))
					sent++;
			end
		end
	endtask

	function automatic logic [31:0] rand_coef();
		if ($urandom_range(0, 4) == 0) return rand_word();
		return 32'($urandom_range(0, 262144)) - 32'd131072;
	endfunction

	task automatic report(input string what, input force_result_t e);
		errors++;
		if (errors <= 10)
			$display("%0t: %s: exp addr %h node %0d f %h %h %h last %b, got addr %h node %0d f %h %h %h last %b",
				$realtime, what, e.addr, e.node, e.fx, e.fy, e.fz, e.lst,
				out_address, out_node, force_x, force_y, force_z, last);
	endtask

	// Receiver: out_stall follows a pattern whose mode is picked again at random at regular intervals.
	int stall_cycle = 0;
	int stall_mode = 0;
	always @(posedge clk) begin
		force_result_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_forces.size() == 0) begin
				e = '{default: '0};
				report("unexpected item", e);
			end else begin
				e = expected_forces.pop_front();
				if (out_address !== e.addr || out_node !== e.node || force_x !== e.fx ||
						force_y !== e.fy || force_z !== e.fz || last !== e.lst)
					report("mismatch", e);
			end
		end
		stall_cycle++;
		if (stall_cycle % 50 == 0)
			stall_mode = $urandom_range(0, 2);
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			default: out_stall <= ($urandom_range(0, 3) != 0);
		endcase
	end

	initial begin
		#16_000_000;
		$display("elastic_element_residual_tb NOT OK");
		$finish;
	end

	// Directed table. Registers are at reset values, so all stresses are zero and each node
	// force must come back unchanged.
	stim_t directed [17];

	initial begin
		cfg_we <= 1'b0;
		cfg_index <= eer_pkg::CFG_L2M;
		cfg_data <= '0;
		in_valid <= 1'b0;
		action <= eer_pkg::ACT_SG;
		point_index <= '0;
		node_index <= '0;
		node_address <= '0;
		val_x <= '0;
		val_y <= '0;
		val_z <= '0;
		force_in_x <= '0;
		force_in_y <= '0;
		force_in_z <= '0;
		out_stall <= 1'b0;
		coef_l2m = 0;
		coef_lam = 0;
		coef_mu = 0;
		nodes_reg = 4;
		points_reg = 1;
		directed = '{
			'{eer_pkg::ACT_SG, 0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0, 0, 0},
			'{eer_pkg::ACT_SG, 0, 1, 0, 32'h0001_0000, 32'hFFFF_FFFF, 1, 0, 0, 0, 0},
			'{eer_pkg::ACT_SG, 0, 2, 0, 32'hFFFF_0000, 32'h0000_8000, 32'h7FFF_FFFF,
				0, 0, 0, 0},
			'{eer_pkg::ACT_SG, 0, 3, 0, 32'h8000_0000, 0, 32'h0002_0000, 0, 0, 0, 0},
			'{eer_pkg::ACT_SG, 15, 31, 0, 32'h1234, 32'h5678, 32'h9ABC, 0, 0, 0, 0},
			'{eer_pkg::ACT_WT, 0, 0, 0, 32'h0001_0000, 0, 0, 0, 0, 0, 0},
			'{eer_pkg::ACT_WT, 15, 31, 0, 32'h7FFF_FFFF, 0, 0, 0, 0, 0, 0},
			'{eer_pkg::ACT_JAC, 0, 0, 0, 32'h0001_0000, 0, 0, 0, 0, 0, 0},
			'{eer_pkg::ACT_JAC, 0, 1, 0, 0, 32'h7FFF_FFFF, 0, 0, 0, 0, 0},
			'{eer_pkg::ACT_JAC, 0, 2, 0, 0, 0, 32'h8000_0000, 0, 0, 0, 0},
			'{eer_pkg::ACT_JAC, 0, 3, 0, 32'h0001_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
				0, 0, 0, 0},
			'{eer_pkg::ACT_JAC, 0, 31, 0, 32'h7FFF_FFFF, 0, 0, 0, 0, 0, 0},
			'{eer_pkg::ACT_NODE, 15, 25, 32'hFFFF_FFFF, 1, 1, 1, 1, 1, 1, 0},
			'{eer_pkg::ACT_NODE, 0, 0, 32'h0, 32'h7FFF_FFFF, 0, 32'h8000_0000,
				32'h7FFF_FFFF, 32'h8000_0000, 0, 1},
			'{eer_pkg::ACT_NODE, 0, 1, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1,
				32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1},
			'{eer_pkg::ACT_NODE, 15, 2, 32'h5555_AAAA, 0, 32'hFFFF_FFFF, 0,
				32'h0001_0000, 0, 32'h7FFF_FFFF, 1},
			'{eer_pkg::ACT_NODE, 9, 3, 32'hAAAA_5555, 32'h0001_0000, 0, 0,
				32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000, 1}
		};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed[i]) begin
			if (directed[i].typed) begin
				typed_addr[directed[i].nd] = directed[i].addr;
				typed_force[directed[i].nd] = '{directed[i].fx, directed[i].fy, directed[i].fz};
			end
			send(directed[i]);
		end

		run_phase(32'h0002_0000, 32'h0001_0000, 32'h0000_8000, 3, 2, 5);
		run_phase(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 1, 5);
		run_phase(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 20, 1, 1);
		// Zero counts clamp up to one; upper data bits are not part of a count.
		run_phase(rand_coef(), rand_coef(), rand_coef(),
			{27'($urandom_range(0, 32'h7FF_FFFF)), 5'd0},
			{27'($urandom_range(0, 32'h7FF_FFFF)), 5'd0}, 5);
		run_phase(rand_coef(), rand_coef(), rand_coef(), 2, 17, 5);
		run_phase(rand_coef(), rand_coef(), rand_coef(), 31, 2, 1);
		run_phase(rand_coef(), rand_coef(), rand_coef(), 5, 3, 5);
		run_phase(rand_coef(), rand_coef(), rand_coef(), $urandom_range(2, 8),
			$urandom_range(1, 4), 10);

		in_valid <= 1'b0;
		while (expected_forces.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("elastic_element_residual_tb OK");
		else
			$display("elastic_element_residual_tb NOT OK");
		$finish;
	end

endmodule
